### rtl/core/json_string_unescape_utf8_core_macros.svh
// Assertion macros for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is held.
`define JSU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSU_ASSERT(label, clk, rst_n, prop, msg)
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/core/jsu_pkg.sv
// Shared types and status codes for the JSON string unescaper.
package jsu_pkg;

    localparam logic [2:0] ST_CONT      = 3'd0;
    localparam logic [2:0] ST_CLOSED    = 3'd1;
    localparam logic [2:0] ST_NO_QUOTE  = 3'd2;
    localparam logic [2:0] ST_BAD_ESC   = 3'd3;
    localparam logic [2:0] ST_BAD_HEX   = 3'd4;
    localparam logic [2:0] ST_BAD_SURR  = 3'd5;
    localparam logic [2:0] ST_CTRL_CHAR = 3'd6;

    // Results of one item: up to four UTF-8 bytes, or one status-only result.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_byte;
        logic [2:0]      status;
    } t_step_res;

endpackage

### rtl/core/jsu_step.sv
// Scanner state and per-item decode: escapes, hex groups, surrogates, UTF-8.
module jsu_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_ends,
    output jsu_pkg::t_step_res o_res
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX1    = 3'd2,
        MODE_WANT_BS = 3'd3,
        MODE_WANT_U  = 3'd4,
        MODE_HEX2    = 3'd5
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } t_hex;

    function automatic t_hex hex_of(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.digit = c[3:0];
        case (c) inside
            [8'h30:8'h39]: h.digit = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: h.digit = c[3:0] + 4'd9;
            default:       h.ok = 1'b0;
        endcase
        return h;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;

    t_hex        w_hx;
    logic [15:0] w_hex_next;
    logic [20:0] w_cp;
    logic        w_emit_cp;
    logic        w_emit_one;
    logic [7:0]  w_one;
    logic [2:0]  w_st;

    always_comb begin
        n_mode     = r_mode;
        n_hex      = r_hex;
        n_cnt      = r_cnt;
        n_hs       = r_hs;
        w_hx       = hex_of(i_byte);
        w_hex_next = {r_hex[11:0], w_hx.digit};
        w_cp       = '0;
        w_emit_cp  = 1'b0;
        w_emit_one = 1'b0;
        w_one      = i_byte;
        w_st       = ST_CONT;
        o_res      = '0;

        if (i_ends) begin
            case (r_mode)
                MODE_ESC:                 w_st = ST_BAD_ESC;
                MODE_HEX1, MODE_HEX2:     w_st = ST_BAD_HEX;
                MODE_WANT_BS, MODE_WANT_U: w_st = ST_BAD_SURR;
                default:                  w_st = ST_NO_QUOTE;
            endcase
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    case (i_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: w_emit_one = 1'b1;
                        CH_B: begin
                            w_emit_one = 1'b1;
                            w_one      = 8'h08;
                        end
                        CH_N: begin
                            w_emit_one = 1'b1;
                            w_one      = 8'h0A;
                        end
                        CH_R: begin
                            w_emit_one = 1'b1;
                            w_one      = 8'h0D;
                        end
                        CH_T: begin
                            w_emit_one = 1'b1;
                            w_one      = 8'h09;
                        end
                        CH_F: begin
                            w_emit_one = 1'b1;
                            w_one      = 8'h0C;
                        end
                        CH_U: begin
                            n_mode = MODE_HEX1;
                            n_hex  = '0;
                            n_cnt  = '0;
                        end
                        default: w_st = ST_BAD_ESC;
                    endcase
                end
                MODE_HEX1, MODE_HEX2: begin
                    if (!w_hx.ok) begin
                        w_st = ST_BAD_HEX;
                    end else if (r_cnt != 2'd3) begin
                        n_hex = w_hex_next;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_hex = '0;
                        n_cnt = '0;
                        if (r_mode == MODE_HEX1) begin
                            // high surrogate D800..DBFF waits for its partner
                            if (w_hex_next[15:10] == 6'b110110) begin
                                n_hs   = w_hex_next[9:0];
                                n_mode = MODE_WANT_BS;
                            end else begin
                                w_emit_cp = 1'b1;
                                w_cp      = {5'd0, w_hex_next};
                                n_mode    = MODE_PLAIN;
                            end
                        end else if (w_hex_next[15:10] != 6'b110111) begin
                            w_st = ST_BAD_SURR;
                        end else begin
                            w_emit_cp = 1'b1;
                            w_cp      = {1'b0, r_hs, w_hex_next[9:0]} + 21'h10000;
                            n_mode    = MODE_PLAIN;
                        end
                    end
                end
                MODE_WANT_BS: begin
                    if (i_byte == CH_BSL) n_mode = MODE_WANT_U;
                    else                  w_st = ST_BAD_SURR;
                end
                MODE_WANT_U: begin
                    if (i_byte == CH_U) begin
                        n_mode = MODE_HEX2;
                        n_hex  = '0;
                        n_cnt  = '0;
                    end else begin
                        w_st = ST_BAD_SURR;
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    if (i_byte == CH_QUOTE)     w_st = ST_CLOSED;
                    else if (i_byte == CH_BSL)  n_mode = MODE_ESC;
                    else if (i_byte < 8'h20)    w_st = ST_CTRL_CHAR;
                    else                        w_emit_one = 1'b1;
                end
            endcase
        end

        if (w_st != ST_CONT) begin
            n_mode = MODE_PLAIN;
            n_hex  = '0;
            n_cnt  = '0;
            n_hs   = '0;
        end

        // UTF-8 encode
        if (w_emit_cp) begin
            o_res.has_byte = 1'b1;
            if (w_cp[20:7] == '0) begin
                o_res.bytes[0] = w_cp[7:0];
                o_res.last_idx = 2'd0;
            end else if (w_cp[20:11] == '0) begin
                o_res.bytes[0] = {3'b110, w_cp[10:6]};
                o_res.bytes[1] = {2'b10, w_cp[5:0]};
                o_res.last_idx = 2'd1;
            end else if (w_cp[20:16] == '0) begin
                o_res.bytes[0] = {4'b1110, w_cp[15:12]};
                o_res.bytes[1] = {2'b10, w_cp[11:6]};
                o_res.bytes[2] = {2'b10, w_cp[5:0]};
                o_res.last_idx = 2'd2;
            end else begin
                o_res.bytes[0] = {5'b11110, w_cp[20:18]};
                o_res.bytes[1] = {2'b10, w_cp[17:12]};
                o_res.bytes[2] = {2'b10, w_cp[11:6]};
                o_res.bytes[3] = {2'b10, w_cp[5:0]};
                o_res.last_idx = 2'd3;
            end
        end else if (w_emit_one) begin
            o_res.has_byte = 1'b1;
            o_res.bytes[0] = w_one;
        end else begin
            o_res.status = w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
        end
    end

endmodule

### rtl/core/json_string_unescape_utf8_core.sv
// JSON string body unescaper with UTF-8 output: top level with stream ports.
//
// Feed the bytes of a JSON string body, one item per byte, starting after the
// opening quote; an item with the end flag in tuser says the text ran out.
// Plain bytes pass through, the short escapes are decoded, \uXXXX (either hex
// case, surrogate pairs joined) comes out as 1 to 4 UTF-8 bytes, one output
// item per byte. The closing quote and each error give one status item with
// no byte, after which the scanner is back in plain text mode. tlast marks the
// final output item of each input item. Rate: one input item per cycle while
// each yields a single output item and the output is not stalled; an item that
// yields more than one byte holds the result register until its last byte is
// taken, and input stalls meanwhile. One item waits in the input register
// while a result is still being taken, then moves on to the result register.
`include "json_string_unescape_utf8_core_macros.svh"

module json_string_unescape_utf8_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] input_ends
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] byte_valid,
                                        // [11:9] status, [15:12] zero
    output logic        m_axis_tlast    // last_of_run
);
    import jsu_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_ends;

    // result register: the bytes of one item, drained one per handshake
    logic       r_ob_valid;
    logic [1:0] r_ob_idx;
    t_step_res  r_ob;

    t_step_res  w_res;
    logic       w_s_acc;
    logic       w_m_acc;
    logic       w_ob_last;
    logic       w_ob_free;
    logic       w_fire;

    assign w_ob_last     = (r_ob_idx == r_ob.last_idx);
    assign w_m_acc       = r_ob_valid && m_axis_tready;
    assign w_ob_free     = !r_ob_valid || (m_axis_tready && w_ob_last);
    assign w_fire        = r_in_valid && w_ob_free;
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    jsu_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_ends  (r_in_ends),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ob_valid <= 1'b0;
            r_ob_idx   <= '0;
        end else begin
            if (w_s_acc)     r_in_valid <= 1'b1;
            else if (w_fire) r_in_valid <= 1'b0;

            if (w_fire) begin
                r_ob_valid <= 1'b1;
                r_ob_idx   <= '0;
            end else if (w_m_acc) begin
                if (w_ob_last) r_ob_valid <= 1'b0;
                else           r_ob_idx   <= r_ob_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_ends <= s_axis_tuser;
        end
        if (w_fire) r_ob <= w_res;
    end

    assign m_axis_tvalid = r_ob_valid;
    assign m_axis_tlast  = w_ob_last;
    assign m_axis_tdata  = {4'd0, r_ob.status, r_ob.has_byte, r_ob.bytes[r_ob_idx]};

    // a status item never carries a byte
    `JSU_ASSERT(a_status_no_byte, i_clk, i_rst_n, (m_axis_tvalid && r_ob.status != ST_CONT) |-> (!r_ob.has_byte && m_axis_tlast), "status item carries a byte")
    // a byteless result is always a single item
    `JSU_ASSERT(a_nobyte_single, i_clk, i_rst_n, (r_ob_valid && !r_ob.has_byte) |-> (r_ob.last_idx == 2'd0), "byteless result spans items")
    // a stalled result is not dropped
    `JSU_ASSERT(a_out_held, i_clk, i_rst_n, (r_ob_valid && !m_axis_tready) |=> (r_ob_valid && $stable(r_ob_idx)), "stalled result lost")
    // drain index never passes the last byte
    `JSU_ASSERT_ALWAYS(a_idx_range, i_clk, r_ob_valid |-> (r_ob_idx <= r_ob.last_idx), "drain index out of range")

endmodule
